@@ src/min_max_feature_normalizer_core_macros.svh @@
// Assertion macros for the normaliser RTL.
// Each expects i_clk and i_rst_n in scope.
`ifndef MIN_MAX_FEATURE_NORMALIZER_CORE_MACROS_SVH
`define MIN_MAX_FEATURE_NORMALIZER_CORE_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define MMFN_ASSERT_HOLDS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define MMFN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/mmfn_pkg.sv @@
package mmfn_pkg;

    localparam int NUM_FEATURES = 32;
    localparam int QUEUE_DEPTH  = 2;
    localparam int DIV_STEPS    = 24;
    localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

    localparam logic [31:0]        ONE_Q16 = 32'd65536;
    localparam logic signed [23:0] OUT_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] OUT_MIN = 24'sh800000;

    typedef enum logic {
        REQ_OBSERVE   = 1'b0,
        REQ_NORMALIZE = 1'b1
    } t_req_type;

    typedef struct packed {
        t_req_type          req_type;
        logic signed [31:0] sample_value;
        logic [4:0]         feature_index;
        logic               first_sample;
    } t_req;

    typedef struct packed {
        logic signed [23:0] normalized_value;
        logic               saturated;
        logic [4:0]         feature_echo;
    } t_res;

    typedef struct packed {
        logic signed [32:0] diff;
        logic [31:0]        range;
        logic [4:0]         idx;
    } t_job;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ABS,
        S_CHK,
        S_DIV,
        S_DONE
    } t_div_state;

endpackage

@@ src/mmfn_front.sv @@
module mmfn_front (
    input  logic              i_clk,
    input  logic              i_in_valid,
    input  mmfn_pkg::t_req    i_in_data,
    output logic              o_in_ready,
    output logic              o_push_valid,
    output mmfn_pkg::t_job    o_push_job,
    input  logic              i_push_ready
);

    logic signed [31:0] r_min [mmfn_pkg::NUM_FEATURES];
    logic signed [31:0] r_max [mmfn_pkg::NUM_FEATURES];

    logic               w_idx_ok;
    logic               w_accept;
    logic signed [31:0] w_mn;
    logic signed [31:0] w_mx;
    logic signed [32:0] w_range;

    assign w_idx_ok   = 32'(i_in_data.feature_index) < 32'(mmfn_pkg::NUM_FEATURES);
    assign o_in_ready = i_push_ready;
    assign w_accept   = i_in_valid && i_push_ready;

    assign w_mn = w_idx_ok ? r_min[i_in_data.feature_index] : 32'sd0;
    assign w_mx = w_idx_ok ? r_max[i_in_data.feature_index] : 32'sd0;

    assign w_range = {w_mx[31], w_mx} - {w_mn[31], w_mn};

    assign o_push_valid    = i_in_valid && (i_in_data.req_type == mmfn_pkg::REQ_NORMALIZE);
    assign o_push_job.diff = {i_in_data.sample_value[31], i_in_data.sample_value}
                           - {w_mn[31], w_mn};
    assign o_push_job.range = (w_range[32] || (w_range == 33'sd0)) ? mmfn_pkg::ONE_Q16
                                                                   : w_range[31:0];
    assign o_push_job.idx  = i_in_data.feature_index;

    always_ff @(posedge i_clk) begin
        if (w_accept && (i_in_data.req_type == mmfn_pkg::REQ_OBSERVE) && w_idx_ok) begin
            if (i_in_data.first_sample) begin
                r_min[i_in_data.feature_index] <= i_in_data.sample_value;
                r_max[i_in_data.feature_index] <= i_in_data.sample_value;
            end else begin
                if (i_in_data.sample_value < w_mn) begin
                    r_min[i_in_data.feature_index] <= i_in_data.sample_value;
                end
                if (i_in_data.sample_value > w_mx) begin
                    r_max[i_in_data.feature_index] <= i_in_data.sample_value;
                end
            end
        end
    end

endmodule

@@ src/mmfn_queue.sv @@
module mmfn_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mmfn_pkg::t_job    i_push_job,
    output logic              o_push_ready,
    output logic              o_pop_valid,
    output mmfn_pkg::t_job    o_pop_job,
    input  logic              i_pop
);

    localparam int PTR_W = (mmfn_pkg::QUEUE_DEPTH > 1) ? $clog2(mmfn_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(mmfn_pkg::QUEUE_DEPTH + 1);

    mmfn_pkg::t_job r_mem [mmfn_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    logic w_push;
    logic w_pop;

    assign o_push_ready = r_count != CNT_W'(mmfn_pkg::QUEUE_DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_job    = r_mem[r_rd];
    assign w_push       = i_push && o_push_ready;
    assign w_pop        = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_W'(mmfn_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(mmfn_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ src/mmfn_divider.sv @@
`include "min_max_feature_normalizer_core_macros.svh"

module mmfn_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    input  mmfn_pkg::t_job    i_job,
    output logic              o_pop,
    output logic              o_out_valid,
    output mmfn_pkg::t_res    o_out_data,
    input  logic              i_out_ready
);

    mmfn_pkg::t_div_state r_state, n_state;

    logic signed [32:0]                r_diff, n_diff;
    logic [31:0]                       r_den, n_den;
    logic [4:0]                        r_idx, n_idx;
    logic                              r_neg, n_neg;
    logic [32:0]                       r_mag, n_mag;
    logic                              r_ovf, n_ovf;
    logic [31:0]                       r_rem, n_rem;
    logic [23:0]                       r_num_lo, n_num_lo;
    logic [23:0]                       r_quo, n_quo;
    logic [mmfn_pkg::DIV_CNT_W-1:0]    r_cnt, n_cnt;
    logic                              r_out_valid, n_out_valid;
    mmfn_pkg::t_res                    r_out, n_out;

    logic [32:0] w_trial;
    logic [32:0] w_sub;
    logic        w_ge;
    logic        w_out_free;

    assign w_trial    = {r_rem, r_num_lo[23]};
    assign w_sub      = w_trial - {1'b0, r_den};
    assign w_ge       = w_trial >= {1'b0, r_den};
    assign w_out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mmfn_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_diff   <= n_diff;
        r_den    <= n_den;
        r_idx    <= n_idx;
        r_neg    <= n_neg;
        r_mag    <= n_mag;
        r_ovf    <= n_ovf;
        r_rem    <= n_rem;
        r_num_lo <= n_num_lo;
        r_quo    <= n_quo;
        r_cnt    <= n_cnt;
        r_out    <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_diff      = r_diff;
        n_den       = r_den;
        n_idx       = r_idx;
        n_neg       = r_neg;
        n_mag       = r_mag;
        n_ovf       = r_ovf;
        n_rem       = r_rem;
        n_num_lo    = r_num_lo;
        n_quo       = r_quo;
        n_cnt       = r_cnt;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        o_pop       = 1'b0;

        unique case (r_state)
            mmfn_pkg::S_IDLE: begin
                if (i_job_valid) begin
                    o_pop   = 1'b1;
                    n_diff  = i_job.diff;
                    n_den   = i_job.range;
                    n_idx   = i_job.idx;
                    n_state = mmfn_pkg::S_ABS;
                end
            end
            mmfn_pkg::S_ABS: begin
                n_neg   = r_diff[32];
                n_mag   = r_diff[32] ? 33'(-r_diff) : 33'(r_diff);
                n_state = mmfn_pkg::S_CHK;
            end
            mmfn_pkg::S_CHK: begin
                n_ovf    = {8'b0, r_mag} >= {1'b0, r_den, 8'b0};
                n_rem    = {7'b0, r_mag[32:8]};
                n_num_lo = {r_mag[7:0], 16'b0};
                n_cnt    = '0;
                n_state  = n_ovf ? mmfn_pkg::S_DONE : mmfn_pkg::S_DIV;
            end
            mmfn_pkg::S_DIV: begin
                n_rem    = w_ge ? w_sub[31:0] : w_trial[31:0];
                n_quo    = {r_quo[22:0], w_ge};
                n_num_lo = {r_num_lo[22:0], 1'b0};
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == mmfn_pkg::DIV_CNT_W'(mmfn_pkg::DIV_STEPS - 1)) begin
                    n_state = mmfn_pkg::S_DONE;
                end
            end
            mmfn_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_out_valid        = 1'b1;
                    n_out.feature_echo = r_idx;
                    if (r_ovf) begin
                        n_out.saturated        = 1'b1;
                        n_out.normalized_value = r_neg ? mmfn_pkg::OUT_MIN : mmfn_pkg::OUT_MAX;
                    end else if (!r_neg) begin
                        n_out.saturated        = r_quo[23];
                        n_out.normalized_value = r_quo[23] ? mmfn_pkg::OUT_MAX
                                                           : $signed(r_quo);
                    end else if (r_quo > 24'h800000) begin
                        n_out.saturated        = 1'b1;
                        n_out.normalized_value = mmfn_pkg::OUT_MIN;
                    end else begin
                        n_out.saturated        = 1'b0;
                        n_out.normalized_value = $signed(24'(-r_quo));
                    end
                    n_state = mmfn_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mmfn_pkg::S_IDLE;
            end
        endcase
    end

    `MMFN_ASSERT_HOLDS(a_rem_below_den, (r_state != mmfn_pkg::S_DIV) || (r_rem < r_den), "divider remainder not below divisor")
    `MMFN_ASSERT_NEXT(a_pop_starts_job, o_pop, r_state == mmfn_pkg::S_ABS, "pop did not start a job")
    `MMFN_ASSERT_HOLDS(a_sat_at_limit, !(r_out_valid && r_out.saturated) || (r_out.normalized_value == mmfn_pkg::OUT_MAX) || (r_out.normalized_value == mmfn_pkg::OUT_MIN), "saturated result off the limits")

endmodule

@@ src/min_max_feature_normalizer_core.sv @@
// A normalise transfer passes from acceptance through the queue, the sign and range check,
// 24 radix-2 divide steps (skipped on overflow) and the output register.
// The serial divider takes one normalise job at a time; later jobs wait in the queue.
// Observe transfers are accepted while the divider is busy, until the queue fills.
// Reset clears the queue, divider state and output valid; the min/max stores
// hold no value until written.
module min_max_feature_normalizer_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  mmfn_pkg::t_req    i_in_data,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output mmfn_pkg::t_res    o_out_data,
    input  logic              i_out_ready
);

    logic           w_push_valid;
    logic           w_push_ready;
    mmfn_pkg::t_job w_push_job;
    logic           w_pop_valid;
    logic           w_pop;
    mmfn_pkg::t_job w_pop_job;

    mmfn_front u_front (
        .i_clk        (i_clk),
        .i_in_valid   (i_in_valid),
        .i_in_data    (i_in_data),
        .o_in_ready   (o_in_ready),
        .o_push_valid (w_push_valid),
        .o_push_job   (w_push_job),
        .i_push_ready (w_push_ready)
    );

    mmfn_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push_valid),
        .i_push_job   (w_push_job),
        .o_push_ready (w_push_ready),
        .o_pop_valid  (w_pop_valid),
        .o_pop_job    (w_pop_job),
        .i_pop        (w_pop)
    );

    mmfn_divider u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_pop_valid),
        .i_job       (w_pop_job),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_ready (i_out_ready)
    );

endmodule
